// ===== src/psc_pkg.sv =====
`timescale 1ns / 1ps

package psc_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_X    = 2'd1,
    REQ_SET_Y    = 2'd2,
    REQ_SET_MODE = 2'd3
  } psc_req_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [1:0] CFG_STEP_PERIOD = 2'd1;
  localparam logic [1:0] CFG_FALLBACK    = 2'd2;

  localparam logic [7:0] CENTER_DEG    = 8'd90;
  localparam logic [7:0] MAX_DEG       = 8'd180;
  localparam logic [7:0] CNT_MAX       = 8'd255;
  localparam logic [7:0] TIMEOUT_RST   = 8'd100;
  localparam logic [7:0] STEP_RST      = 8'd30;
  localparam logic [7:0] FALLBACK_RST  = 8'd100;

  typedef struct packed {
    psc_req_e   req_type;
    logic [7:0] value;
    logic       manual_on;
  } psc_in_t;

  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       manual_mode;
    logic       swept;
  } psc_out_t;

  // Sweep state of one axis
  typedef struct packed {
    logic [7:0] angle;
    logic       down;
  } psc_axis_t;

  // Clip an angle or range to the servo limit
  function automatic logic [7:0] sat_deg(logic [7:0] v);
    sat_deg = (v > MAX_DEG) ? MAX_DEG : v;
  endfunction

endpackage

// ===== src/psc_axis.sv =====
`timescale 1ns / 1ps

module psc_axis (
  input  psc_pkg::psc_axis_t axis_i,
  input  logic [7:0]         range_i,
  output psc_pkg::psc_axis_t axis_o
);
  import psc_pkg::*;

  logic signed [9:0] lo;
  logic signed [9:0] hi;
  logic signed [9:0] half;
  logic signed [9:0] nxt;
  logic signed [9:0] clp;
  logic              flip;

  // Bounds sit half the range either side of centre
  assign half = $signed({3'b000, range_i[7:1]});
  assign lo   = $signed({2'b00, CENTER_DEG}) - half;
  assign hi   = $signed({2'b00, CENTER_DEG}) + half;

  // Advance one degree without wrap
  assign nxt  = $signed({2'b00, axis_i.angle}) + (axis_i.down ? -10'sd1 : 10'sd1);
  assign flip = (nxt <= lo) || (nxt >= hi);

  // Clamp onto the bound and reverse when it is reached
  always_comb begin
    clp = nxt;
    if (nxt < lo) begin
      clp = lo;
    end else if (nxt > hi) begin
      clp = hi;
    end
  end

  assign axis_o.angle = clp[7:0];
  assign axis_o.down  = flip ? ~axis_i.down : axis_i.down;

endmodule

// ===== src/psc_core.sv =====
`timescale 1ns / 1ps

module psc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               fire_i,
  input  psc_pkg::psc_in_t   item_i,
  output logic               is_tick_o,
  output psc_pkg::psc_out_t  res_o
);
  import psc_pkg::*;

  logic [7:0] timeout_q, step_period_q, fallback_q;
  logic [7:0] target_x_q, target_x_d, target_y_q, target_y_d;
  logic [7:0] range_x_q, range_x_d, range_y_q, range_y_d;
  logic       manual_q, manual_d;
  logic [7:0] silence_q, silence_d, since_q, since_d;
  psc_axis_t  ax_x_q, ax_x_d, ax_y_q, ax_y_d;
  psc_axis_t  sw_x, sw_y;
  logic [7:0] val;
  logic [7:0] sil_inc, since_inc;
  logic       step;

  // Configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RST;
      step_period_q <= STEP_RST;
      fallback_q    <= FALLBACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT:     timeout_q     <= cfg_wdata_i;
        CFG_STEP_PERIOD: step_period_q <= cfg_wdata_i;
        CFG_FALLBACK:    fallback_q    <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Step both axes from the ranges in force after the timeout check
  psc_axis u_axis_x (.axis_i(ax_x_q), .range_i(range_x_d), .axis_o(sw_x));
  psc_axis u_axis_y (.axis_i(ax_y_q), .range_i(range_y_d), .axis_o(sw_y));

  assign val       = sat_deg(item_i.value);
  assign sil_inc   = (silence_q == CNT_MAX) ? CNT_MAX : silence_q + 8'd1;
  assign since_inc = (since_q == CNT_MAX) ? CNT_MAX : since_q + 8'd1;
  assign is_tick_o = (item_i.req_type == REQ_TICK);

  // Next state for one item
  always_comb begin
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    range_x_d  = range_x_q;
    range_y_d  = range_y_q;
    manual_d   = manual_q;
    silence_d  = silence_q;
    since_d    = since_q;
    ax_x_d     = ax_x_q;
    ax_y_d     = ax_y_q;
    step       = 1'b0;
    unique case (item_i.req_type)
      REQ_SET_X: begin
        if (manual_q) target_x_d = val;
        else          range_x_d  = val;
        silence_d = '0;
      end
      REQ_SET_Y: begin
        if (manual_q) target_y_d = val;
        else          range_y_d  = val;
        silence_d = '0;
      end
      REQ_SET_MODE: begin
        manual_d  = item_i.manual_on;
        silence_d = '0;
      end
      REQ_TICK: begin
        silence_d = sil_inc;
        since_d   = since_inc;
        // Drop manual mode after too long a silence
        if (manual_q && (sil_inc > timeout_q)) begin
          manual_d  = 1'b0;
          range_x_d = sat_deg(fallback_q);
          range_y_d = sat_deg(fallback_q);
        end
        if (!manual_d && (since_inc >= step_period_q)) begin
          step    = 1'b1;
          since_d = '0;
          ax_x_d  = sw_x;
          ax_y_d  = sw_y;
        end
      end
      default: ;
    endcase
  end

  // Result of a tick
  assign res_o.pos_x       = manual_d ? target_x_d : ax_x_d.angle;
  assign res_o.pos_y       = manual_d ? target_y_d : ax_y_d.angle;
  assign res_o.manual_mode = manual_d;
  assign res_o.swept       = step;

  // Hold state, advance on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q <= CENTER_DEG;
      target_y_q <= CENTER_DEG;
      range_x_q  <= MAX_DEG;
      range_y_q  <= MAX_DEG;
      manual_q   <= 1'b0;
      silence_q  <= '0;
      since_q    <= '0;
      ax_x_q     <= '{angle: CENTER_DEG, down: 1'b0};
      ax_y_q     <= '{angle: CENTER_DEG, down: 1'b0};
    end else if (fire_i) begin
      target_x_q <= target_x_d;
      target_y_q <= target_y_d;
      range_x_q  <= range_x_d;
      range_y_q  <= range_y_d;
      manual_q   <= manual_d;
      silence_q  <= silence_d;
      since_q    <= since_d;
      ax_x_q     <= ax_x_d;
      ax_y_q     <= ax_y_d;
    end
  end

endmodule

// ===== src/pan_sweep_servo_controller.sv =====
`timescale 1ns / 1ps
// A tick beat leaves after acceptance through the input register and then the result register.
// Commands update state and produce no output beat.
// Throughput: one beat per cycle; the input register and the result register stall only
// while a result waits on out_ready_i.
// Reset: rst_ni clears all state and valid flags asynchronously; payload registers are
// not reset; no clearing pass.

module pan_sweep_servo_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psc_pkg::psc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psc_pkg::psc_out_t out_data_o
);
  import psc_pkg::*;

  logic     s1_valid_q;
  psc_in_t  s1_data_q;
  logic     out_valid_q;
  psc_out_t out_data_q;
  logic     out_free;
  logic     s1_fire;
  logic     is_tick;
  psc_out_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  psc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (s1_fire),
    .item_i     (s1_data_q),
    .is_tick_o  (is_tick),
    .res_o      (res)
  );

  // Result register; only ticks produce a beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && is_tick) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/psc_checker.sv =====
`timescale 1ns / 1ps

module psc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input psc_pkg::psc_out_t out_data_o
);
  import psc_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Input stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Angles stay within the servo limit
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pos_x <= MAX_DEG) && (out_data_o.pos_y <= MAX_DEG))
    else $error("position beyond servo limit");

  // A sweep step never happens in manual mode
  a_sweep_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.swept |-> !out_data_o.manual_mode)
    else $error("sweep step reported in manual mode");

endmodule

bind pan_sweep_servo_controller psc_checker u_psc_checker (.*);
